// File: hdl/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants for the STOMP frame deframer
// Character codes, parser phases, field kinds, error codes and the result
// record that travels from the parser to the output register.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam int unsigned CFG_NUM_REGS = 2;
	localparam int unsigned CFG_IDX_W    = $clog2(CFG_NUM_REGS);
	localparam int unsigned CFG_DATA_W   = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EAT_NEWLINE_AFTER_END = 1'b0,
		CFG_STRIP_VALUE_SPACE     = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_CMD           = 4'd0,
		PH_AFTER_END     = 4'd1,
		PH_HDR_AFTER_CMD = 4'd2,
		PH_HDR_START     = 4'd3,
		PH_KEY           = 4'd4,
		PH_VAL_FIRST     = 4'd5,
		PH_VAL           = 4'd6,
		PH_BODY          = 4'd7,
		PH_DISCARD       = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		K_NONE = 3'd0,
		K_CMD  = 3'd1,
		K_KEY  = 3'd2,
		K_VAL  = 3'd3,
		K_BODY = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE        = 2'd0,
		ERR_NUL_AFT_CMD = 2'd1,
		ERR_NUL_HDR     = 2'd2,
		ERR_NO_COLON    = 2'd3
	} err_t;

	typedef struct packed {
		logic       eat_newline_after_end;
		logic       strip_value_space;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       data_valid;
		kind_t      field_kind;
		logic       field_end;
		logic       frame_end;
		err_t       error_code;
	} res_t;

endpackage

// File: hdl/sfd_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_byte_if / sfd_result_if: valid-ready channels of the deframer
// The byte channel carries one raw stream byte per item; the result channel
// carries the labelled byte with its field and error marks.
// ----------------------------------------------------------------------------
interface sfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface sfd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       data_valid;
	logic [2:0] field_kind;
	logic       field_end;
	logic       frame_end;
	logic [1:0] error_code;

	modport source (output valid, output out_byte, output data_valid, output field_kind,
		output field_end, output frame_end, output error_code, input ready);
	modport sink   (input valid, input out_byte, input data_valid, input field_kind,
		input field_end, input frame_end, input error_code, output ready);
endinterface

// File: hdl/stomp_frame_deframer_unit.sv
`timescale 1ns / 1ps
// A byte passes through the input register, then the result register, where its result is valid.
// Throughput: one byte per cycle while the result channel is not stalled; the parse phase advances once per byte.
// A stalled result holds in the result register while one more byte waits in the input register.
// Reset clears both pipeline valids, sets the phase to awaiting command start and
// sets both configuration flags to 1.
// ----------------------------------------------------------------------------
// stomp_frame_deframer_unit: STOMP receive stream deframer
// Labels each received byte as command, header key, header value or body,
// drops delimiters with field and frame end marks and flags malformed frames.
// ----------------------------------------------------------------------------
module stomp_frame_deframer_unit
	import sfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	sfd_byte_if.sink              in_ch,
	sfd_result_if.source          out_ch
);

	cfg_t       cfg;
	res_t       res;
	res_t       res_s2;
	logic       valid_s1;
	logic       valid_s2;
	logic [7:0] byte_s1;
	logic       advance;
	logic       in_fire;

	assign advance  = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_fire  = in_ch.valid && in_ch.ready;

	sfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	sfd_parse_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.cur_byte (byte_s1),
		.cfg      (cfg),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) valid_s2 <= 1'b1;
			else if (out_ch.ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) byte_s1 <= in_ch.in_byte;
		if (advance) res_s2 <= res;
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.out_byte   = res_s2.out_byte;
	assign out_ch.data_valid = res_s2.data_valid;
	assign out_ch.field_kind = res_s2.field_kind;
	assign out_ch.field_end  = res_s2.field_end;
	assign out_ch.frame_end  = res_s2.frame_end;
	assign out_ch.error_code = res_s2.error_code;

endmodule

// File: hdl/sfd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_cfg_regs: configuration registers
// Decodes the write port into the newline-eating and space-stripping flags.
// ----------------------------------------------------------------------------
module sfd_cfg_regs
	import sfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eat_newline_after_end <= 1'b1;
			cfg_q.strip_value_space     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_EAT_NEWLINE_AFTER_END: cfg_q.eat_newline_after_end <= cfg_wdata[0];
				CFG_STRIP_VALUE_SPACE:     cfg_q.strip_value_space     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/sfd_parse_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_parse_fsm: frame parser state machine
// Holds the parse phase, labels the current byte and advances the phase
// when the byte moves on to the result register.
// ----------------------------------------------------------------------------
module sfd_parse_fsm
	import sfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] cur_byte,
	input  cfg_t       cfg,
	output res_t       res
);

	phase_t phase_q;
	phase_t phase_nxt;
	logic   is_nl;
	logic   is_nul;
	logic   is_colon;
	logic   is_space;

	assign is_nl    = (cur_byte == CH_NL);
	assign is_nul   = (cur_byte == CH_NUL);
	assign is_colon = (cur_byte == CH_COLON);
	assign is_space = (cur_byte == CH_SPACE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
		end else if (advance) begin
			phase_q <= phase_nxt;
		end
	end

	always_comb begin
		phase_nxt = phase_q;
		unique case (phase_q)
			PH_AFTER_END: begin
				if (is_nl && cfg.eat_newline_after_end) phase_nxt = PH_CMD;
				else if (is_nl) phase_nxt = PH_HDR_AFTER_CMD;
				else phase_nxt = PH_CMD;
			end
			PH_HDR_AFTER_CMD, PH_HDR_START: begin
				priority if (is_nl) phase_nxt = PH_BODY;
				else if (is_nul) phase_nxt = PH_AFTER_END;
				else if (is_colon) phase_nxt = PH_VAL_FIRST;
				else phase_nxt = PH_KEY;
			end
			PH_KEY: begin
				priority if (is_colon) phase_nxt = PH_VAL_FIRST;
				else if (is_nl) phase_nxt = PH_DISCARD;
				else phase_nxt = PH_KEY;
			end
			PH_VAL_FIRST, PH_VAL: begin
				if (is_nl) phase_nxt = PH_HDR_START;
				else phase_nxt = PH_VAL;
			end
			PH_BODY: begin
				if (is_nul) phase_nxt = PH_AFTER_END;
			end
			PH_DISCARD: begin
				if (is_nul) phase_nxt = PH_AFTER_END;
			end
			default: begin
				if (is_nl) phase_nxt = PH_HDR_AFTER_CMD;
				else phase_nxt = PH_CMD;
			end
		endcase
	end

	always_comb begin
		res = '{out_byte: 8'h00, data_valid: 1'b0, field_kind: K_NONE,
			field_end: 1'b0, frame_end: 1'b0, error_code: ERR_NONE};
		unique case (phase_q)
			PH_HDR_AFTER_CMD, PH_HDR_START: begin
				priority if (is_nl) begin
				end else if (is_nul) begin
					res.error_code = (phase_q == PH_HDR_AFTER_CMD) ? ERR_NUL_AFT_CMD
						: ERR_NUL_HDR;
				end else if (is_colon) begin
					res.field_kind = K_KEY;
					res.field_end  = 1'b1;
				end else begin
					res.out_byte   = cur_byte;
					res.data_valid = 1'b1;
					res.field_kind = K_KEY;
				end
			end
			PH_KEY: begin
				priority if (is_colon) begin
					res.field_kind = K_KEY;
					res.field_end  = 1'b1;
				end else if (is_nl) begin
					res.error_code = ERR_NO_COLON;
				end else begin
					res.out_byte   = cur_byte;
					res.data_valid = 1'b1;
					res.field_kind = K_KEY;
				end
			end
			PH_VAL_FIRST, PH_VAL: begin
				if (phase_q == PH_VAL_FIRST && is_space && cfg.strip_value_space) begin
				end else if (is_nl) begin
					res.field_kind = K_VAL;
					res.field_end  = 1'b1;
				end else begin
					res.out_byte   = cur_byte;
					res.data_valid = 1'b1;
					res.field_kind = K_VAL;
				end
			end
			PH_BODY: begin
				res.field_kind = K_BODY;
				if (is_nul) begin
					res.field_end = 1'b1;
					res.frame_end = 1'b1;
				end else begin
					res.out_byte   = cur_byte;
					res.data_valid = 1'b1;
				end
			end
			PH_DISCARD: ;
			default: begin
				if (phase_q == PH_AFTER_END && is_nl && cfg.eat_newline_after_end) begin
				end else if (is_nl) begin
					res.field_kind = K_CMD;
					res.field_end  = 1'b1;
				end else begin
					res.out_byte   = cur_byte;
					res.data_valid = 1'b1;
					res.field_kind = K_CMD;
				end
			end
		endcase
	end

endmodule
